// ===== rtl/tcda_pkg.sv =====
// ----------------------------------------------------------------------------
// tcda_pkg: shared definitions of the two-class direction arbiter
// Result status codes, queue numbering and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tcda_pkg;

    // Default depth of each of the four requester queues.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Number of queues: one for each direction and class.
    localparam int NUM_QUEUES = 4;

    // Fixed field widths.
    localparam int ID_W     = 8;
    localparam int STREAK_W = 4;

    // Streak saturation value and reset value of the streak limit.
    localparam logic [STREAK_W-1:0] STREAK_MAX       = 4'd15;
    localparam logic [STREAK_W-1:0] STREAK_LIMIT_RST = 4'd3;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_STREAK_LIMIT = 2'd0;

    // Request kinds.
    localparam logic REQ_ENQUEUE  = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // Directions.
    localparam logic DIR_EAST = 1'b0;
    localparam logic DIR_WEST = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_GRANTED = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_QUEUED  = 2'd2,
        STATUS_FULL    = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/tcda_ram.sv =====
// ----------------------------------------------------------------------------
// tcda_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/two_class_direction_arbiter.sv =====
// A result is registered and appears on the master side in the cycle after its transaction is accepted.
// One item per cycle while the master side takes results; the single result register refills in the cycle it drains.
// The id store is one RAM of 4 x QUEUE_DEPTH entries with a registered read port.
// Reset (synchronous, active low) clears queue heads, counts, streak, last direction
// and sets the streak limit to 3; the id store needs no clearing pass.
// ----------------------------------------------------------------------------
// two_class_direction_arbiter: four-queue grant arbiter with direction streaks
// Enqueues requester ids per direction and class and grants one id per
// dispatch, high class first, alternating directions, forcing a turn after
// a programmable streak of grants in one direction.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_direction_arbiter
    import tcda_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave side: tdata = {high_priority[9], direction[8], train_id[7:0]}
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // tuser = {req_type[0]}
    input  wire logic        s_axis_tuser,
    // Master side: tdata = {granted_priority[9], granted_direction[8], granted_id[7:0]}
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,
    // tuser = {status[1:0]}
    output logic      [1:0]  m_axis_tuser,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    // State.
    logic [HEAD_W-1:0]   r_head  [NUM_QUEUES];
    logic [CNT_W-1:0]    r_count [NUM_QUEUES];
    logic                r_last_dir;
    logic [STREAK_W-1:0] r_streak;
    logic [STREAK_W-1:0] r_streak_limit;

    // Result register.
    logic                r_out_valid;
    t_status             r_status;
    logic                r_gdir;
    logic                r_ghi;

    // Input fields.
    logic            in_req;
    logic [ID_W-1:0] in_id;
    logic            in_dir;
    logic            in_hi;
    logic            in_accept;

    // Decision.
    logic [NUM_QUEUES-1:0] has;
    logic [1:0]            enq_q;
    logic                  enq_full;
    logic [SUM_W-1:0]      pos_sum;
    logic [HEAD_W-1:0]     enq_pos;
    logic                  forced;
    logic                  opp;
    logic                  g_found;
    logic                  g_dir;
    logic                  g_hi;
    logic [1:0]            g_q;
    logic [HEAD_W-1:0]     g_head_next;
    logic                  do_enq;
    logic                  do_grant;
    t_status               n_status;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [ID_W-1:0]       ram_rdata;

    assign in_id  = s_axis_tdata[7:0];
    assign in_dir = s_axis_tdata[8];
    assign in_hi  = s_axis_tdata[9];
    assign in_req = s_axis_tuser;

    // Accept whenever the result register is empty or drains this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Queue occupancy flags; queue number is direction * 2 + class.
    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            has[q] = (r_count[q] != '0);
        end
    end

    // Enqueue position: head plus count, wrapped at the queue depth.
    assign enq_q    = {in_dir, in_hi};
    assign enq_full = (r_count[enq_q] == CNT_W'(QUEUE_DEPTH));
    assign pos_sum  = SUM_W'(r_head[enq_q]) + SUM_W'(r_count[enq_q]);
    assign enq_pos  = (pos_sum >= SUM_W'(QUEUE_DEPTH))
                    ? HEAD_W'(pos_sum - SUM_W'(QUEUE_DEPTH))
                    : HEAD_W'(pos_sum);

    // Grant selection: forced turn first, then high before low, alternating.
    assign forced = (r_streak >= r_streak_limit);
    assign opp    = ~r_last_dir;

    always_comb begin
        g_found = 1'b1;
        g_dir   = DIR_EAST;
        g_hi    = 1'b1;
        if (forced && has[{opp, 1'b1}]) begin
            g_dir = opp;
            g_hi  = 1'b1;
        end else if (forced && has[{opp, 1'b0}]) begin
            g_dir = opp;
            g_hi  = 1'b0;
        end else if (has[{DIR_EAST, 1'b1}] && has[{DIR_WEST, 1'b1}]) begin
            g_dir = opp;
            g_hi  = 1'b1;
        end else if (has[{DIR_EAST, 1'b1}]) begin
            g_dir = DIR_EAST;
            g_hi  = 1'b1;
        end else if (has[{DIR_WEST, 1'b1}]) begin
            g_dir = DIR_WEST;
            g_hi  = 1'b1;
        end else if (has[{DIR_EAST, 1'b0}] && has[{DIR_WEST, 1'b0}]) begin
            g_dir = opp;
            g_hi  = 1'b0;
        end else if (has[{DIR_EAST, 1'b0}]) begin
            g_dir = DIR_EAST;
            g_hi  = 1'b0;
        end else if (has[{DIR_WEST, 1'b0}]) begin
            g_dir = DIR_WEST;
            g_hi  = 1'b0;
        end else begin
            g_found = 1'b0;
        end
    end

    assign g_q         = {g_dir, g_hi};
    assign g_head_next = (r_head[g_q] == HEAD_W'(QUEUE_DEPTH - 1))
                       ? '0 : r_head[g_q] + HEAD_W'(1);

    // Operation of the accepted transaction and its status.
    assign do_enq   = in_accept && (in_req == REQ_ENQUEUE) && !enq_full;
    assign do_grant = in_accept && (in_req == REQ_DISPATCH) && g_found;

    always_comb begin
        if (in_req == REQ_ENQUEUE) begin
            n_status = enq_full ? STATUS_FULL : STATUS_QUEUED;
        end else begin
            n_status = g_found ? STATUS_GRANTED : STATUS_EMPTY;
        end
    end

    // Store addresses: queue base plus position within the queue.
    assign waddr = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(enq_pos);
    assign raddr = ADDR_W'(g_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[g_q]);

    tcda_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (do_enq),
        .i_waddr (waddr),
        .i_wdata (in_id),
        .i_re    (do_grant),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Queue pointers, occupancy and streak tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
            end
            r_last_dir <= DIR_EAST;
            r_streak   <= '0;
        end else begin
            if (do_enq) begin
                r_count[enq_q] <= r_count[enq_q] + CNT_W'(1);
            end
            if (do_grant) begin
                r_head[g_q]  <= g_head_next;
                r_count[g_q] <= r_count[g_q] - CNT_W'(1);
                if (g_dir == r_last_dir) begin
                    if (r_streak != STREAK_MAX) begin
                        r_streak <= r_streak + STREAK_W'(1);
                    end
                end else begin
                    r_last_dir <= g_dir;
                    r_streak   <= STREAK_W'(1);
                end
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the granted id comes from the RAM read register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= n_status;
            r_gdir   <= do_grant ? g_dir : 1'b0;
            r_ghi    <= do_grant ? g_hi : 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'b0, r_ghi, r_gdir,
                            (r_status == STATUS_GRANTED) ? ram_rdata : ID_W'(0)};

    // Configuration register: the only register lies at address 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_limit <= STREAK_LIMIT_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_STREAK_LIMIT)) begin
            r_streak_limit <= pwdata[STREAK_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {28'd0, r_streak_limit};

endmodule

`default_nettype wire

// ===== tb/sv/tb_two_class_direction_arbiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_class_direction_arbiter: self-checking bench of the grant arbiter
// Drives enqueue and dispatch requests over the slave stream and compares
// every result against a cycle-free model of the four requester queues and
// the direction streak. Several streak limits are programmed over APB
// between phases, and both stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------

module tb_two_class_direction_arbiter;
    import tcda_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;

    // Expected result of one request.
    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] id;
        logic            dir;
        logic            pri;
    } t_grant_result;

    // Tracks queue contents and streak state, and holds the results still owed.
    class grant_tracker;
        logic [ID_W-1:0] ids [4][QDEPTH];
        int unsigned     heads [4];
        int unsigned     counts [4];
        int              last_dir;
        int unsigned     streak;
        int unsigned     limit;
        t_grant_result   awaited_results [$];
        int              errors;

        function new();
            foreach (heads[q]) begin
                heads[q]  = 0;
                counts[q] = 0;
            end
            last_dir = DIR_EAST;
            streak   = 0;
            limit    = STREAK_LIMIT_RST;
            errors   = 0;
        endfunction

        function void set_limit(int unsigned value);
            limit = value & 4'hF;
        endfunction

        // Direction to serve within one class, or -1 when the class is empty.
        function int pick_direction(int hi);
            bit east_waits;
            bit west_waits;
            east_waits = counts[DIR_EAST * 2 + hi] != 0;
            west_waits = counts[DIR_WEST * 2 + hi] != 0;
            if (east_waits && west_waits) return last_dir ^ 1;
            if (east_waits) return DIR_EAST;
            if (west_waits) return DIR_WEST;
            return -1;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic req, logic [ID_W-1:0] id, logic dir, logic hi);
            t_grant_result r;
            int            q;
            int            gdir;
            int            ghi;
            int            opp;
            r    = '0;
            gdir = -1;
            ghi  = 0;
            if (req == REQ_ENQUEUE) begin
                q = dir * 2 + hi;
                if (counts[q] >= QDEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    ids[q][(heads[q] + counts[q]) % QDEPTH] = id;
                    counts[q]++;
                    r.status = STATUS_QUEUED;
                end
            end else begin
                // A long streak turns the grant to the other direction if it has work.
                if (streak >= limit) begin
                    opp = last_dir ^ 1;
                    if (counts[opp * 2 + 1] != 0) begin
                        gdir = opp;
                        ghi  = 1;
                    end else if (counts[opp * 2] != 0) begin
                        gdir = opp;
                        ghi  = 0;
                    end
                end
                if (gdir < 0) begin
                    ghi  = 1;
                    gdir = pick_direction(1);
                    if (gdir < 0) begin
                        ghi  = 0;
                        gdir = pick_direction(0);
                    end
                end
                if (gdir < 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    q        = gdir * 2 + ghi;
                    r.status = STATUS_GRANTED;
                    r.id     = ids[q][heads[q]];
                    r.dir    = gdir[0];
                    r.pri    = ghi[0];
                    heads[q] = (heads[q] + 1) % QDEPTH;
                    counts[q]--;
                    if (gdir == last_dir) begin
                        if (streak < STREAK_MAX) streak++;
                    end else begin
                        last_dir = gdir;
                        streak   = 1;
                    end
                end
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_grant(logic [1:0] user, logic [15:0] data);
            t_grant_result e;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, user, data);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            compare_field("status", e.status, user);
            compare_field("granted_id", e.id, data[7:0]);
            compare_field("granted_direction", e.dir, data[8]);
            compare_field("granted_priority", e.pri, data[9]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [1:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    wire  [31:0] prdata;
    wire         pready;

    bit          idle_on = 1'b0;
    int unsigned rx_hold = 0;
    grant_tracker tracker = new();

    two_class_direction_arbiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watch both stream sides; results are checked before new requests are noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_grant(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_request(s_axis_tuser, s_axis_tdata[7:0],
                                     s_axis_tdata[8], s_axis_tdata[9]);
        end
    end

    // Result side stalls in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_hold       <= $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Present one request and hold it until the transaction completes.
    task automatic send_request(logic req, logic [ID_W-1:0] id, logic dir, logic hi);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {6'd0, hi, dir, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write of the streak limit, done only while the block is idle.
    task automatic write_streak_limit(logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STREAK_LIMIT;
        pwdata  <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_limit(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random requests with a given share of enqueues and of east traffic.
    task automatic run_mix(int count, int enq_pct, int east_pct);
        logic req;
        logic dir;
        for (int n = 0; n < count; n++) begin
            req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DISPATCH;
            dir = ($urandom_range(0, 99) < east_pct) ? DIR_EAST : DIR_WEST;
            send_request(req, ID_W'($urandom_range(0, 255)), dir,
                         1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dispatch, id extremes in every queue, alternation,
        // class order, and a forced turn toward a low-class waiter.
        send_request(REQ_DISPATCH, 8'h00, DIR_EAST, 1'b0);
        send_request(REQ_ENQUEUE, 8'hFF, DIR_EAST, 1'b1);
        send_request(REQ_ENQUEUE, 8'h00, DIR_WEST, 1'b1);
        send_request(REQ_ENQUEUE, 8'h80, DIR_EAST, 1'b0);
        send_request(REQ_ENQUEUE, 8'h7F, DIR_WEST, 1'b0);
        send_request(REQ_ENQUEUE, 8'h01, DIR_EAST, 1'b1);
        repeat (6) send_request(REQ_DISPATCH, 8'hFF, DIR_WEST, 1'b1);
        for (int n = 0; n < 4; n++)
            send_request(REQ_ENQUEUE, ID_W'(8'h10 + n), DIR_EAST, 1'b1);
        send_request(REQ_ENQUEUE, 8'hA5, DIR_WEST, 1'b0);
        repeat (5) send_request(REQ_DISPATCH, 8'h00, DIR_EAST, 1'b0);
        drain_results();

        // Shortest nonzero limit, with idling and a pause for all results midway.
        idle_on <= 1'b1;
        write_streak_limit(4'd1);
        run_mix(75, 55, 50);
        drain_results();
        run_mix(75, 55, 50);
        drain_results();

        // Longest limit with mostly east traffic, so long streaks build up.
        write_streak_limit(4'd15);
        run_mix(150, 60, 90);
        drain_results();

        // Zero limit: the other direction is always preferred.
        idle_on <= 1'b0;
        write_streak_limit(4'd0);
        run_mix(100, 50, 50);
        drain_results();

        // Enqueue-heavy traffic fills queues to overflow.
        idle_on <= 1'b1;
        write_streak_limit(4'($urandom_range(2, 14)));
        run_mix(150, 80, 50);
        drain_results();

        // Dispatch-heavy traffic keeps queues near empty.
        write_streak_limit(4'd7);
        run_mix(100, 30, 20);
        drain_results();

        // Last stretch at the reset limit, without idling.
        idle_on <= 1'b0;
        write_streak_limit(STREAK_LIMIT_RST);
        run_mix(100, 52, 50);
        drain_results();

        if (tracker.errors == 0) begin
            $display("tb_two_class_direction_arbiter passed");
        end else begin
            $display("tb_two_class_direction_arbiter failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(2_000_000);
        $display("tb_two_class_direction_arbiter failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcda_pkg.sv
rtl/tcda_ram.sv
rtl/two_class_direction_arbiter.sv
tb/sv/tb_two_class_direction_arbiter.sv
